/* rtl/core/srb_pkg.sv */
package srb_pkg;

   localparam int RING_DEPTH_DEFAULT = 4096;
   localparam int MAX_POP_DEFAULT    = 64;

   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 4;
   localparam int CEIL_W    = 13;
   localparam int LEVEL_W   = 13;
   localparam int POP_MAX_W = 7;
   localparam int OP_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int AUDIO_HZ = 48000;
   localparam logic [CEIL_W-1:0] CEILING_RESET = CEIL_W'(AUDIO_HZ * 6 / 100);
   localparam logic [CHAN_W-1:0] CHANNELS_RESET = CHAN_W'(2);

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   localparam logic REG_CHANNEL_COUNT   = 1'b0;
   localparam logic REG_LATENCY_CEILING = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]             op;
      logic signed [SAMPLE_W-1:0]  sample_ch0;
      logic signed [SAMPLE_W-1:0]  sample_ch1;
      logic                        end_of_packet;
      logic [POP_MAX_W-1:0]        pop_max;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  left;
      logic signed [SAMPLE_W-1:0]  right;
      logic                        frame_valid;
      logic                        last;
      logic [LEVEL_W-1:0]          level;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic flush;
      logic pop_start;
      logic read;
      logic load_frame;
      logic load_empty;
   } cmd_type;

   typedef struct packed {
      logic pop_none;
      logic count_zero;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/srb_csr.sv */
module srb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [srb_pkg::CHAN_W-1:0]        channel_count,
   output logic [srb_pkg::CEIL_W-1:0]        latency_ceiling
);

   logic [srb_pkg::CHAN_W-1:0] channel_count_ff, channel_count_in;
   logic [srb_pkg::CEIL_W-1:0] latency_ceiling_ff, latency_ceiling_in;
   logic                       write_en;
   logic                       reg_index;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_comb begin
      channel_count_in   = channel_count_ff;
      latency_ceiling_in = latency_ceiling_ff;
      if (write_en) begin
         case (reg_index)
            srb_pkg::REG_CHANNEL_COUNT: begin
               channel_count_in = csr_pwdata[srb_pkg::CHAN_W-1:0];
            end
            srb_pkg::REG_LATENCY_CEILING: begin
               latency_ceiling_in = csr_pwdata[srb_pkg::CEIL_W-1:0];
            end
            default: begin
               channel_count_in = channel_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         srb_pkg::REG_CHANNEL_COUNT: begin
            csr_prdata = srb_pkg::CSR_DATA_W'(channel_count_ff);
         end
         srb_pkg::REG_LATENCY_CEILING: begin
            csr_prdata = srb_pkg::CSR_DATA_W'(latency_ceiling_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff   <= srb_pkg::CHANNELS_RESET;
         latency_ceiling_ff <= srb_pkg::CEILING_RESET;
      end else begin
         channel_count_ff   <= channel_count_in;
         latency_ceiling_ff <= latency_ceiling_in;
      end
   end

   assign channel_count   = channel_count_ff;
   assign latency_ceiling = latency_ceiling_ff;

endmodule

/* rtl/core/srb_ctrl.sv */
module srb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [srb_pkg::OP_W-1:0]   req_op,
   output logic                       req_stall,
   input  srb_pkg::status_type        status,
   output srb_pkg::cmd_type           cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_LOAD  = 4'b0100,
      S_EMPTY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  srb_pkg::OP_PUSH: begin
                     cmd.push = 1'b1;
                  end
                  srb_pkg::OP_POP: begin
                     cmd.pop_start = 1'b1;
                     state_in = status.pop_none ? S_EMPTY : S_READ;
                  end
                  srb_pkg::OP_FLUSH: begin
                     cmd.flush = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.load_frame = 1'b1;
               state_in = status.count_zero ? S_IDLE : S_READ;
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.load_empty = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/srb_datapath.sv */
module srb_datapath #(
   parameter int RING_DEPTH = srb_pkg::RING_DEPTH_DEFAULT,
   parameter int MAX_POP    = srb_pkg::MAX_POP_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  srb_pkg::req_type            req_data,
   input  logic [srb_pkg::CHAN_W-1:0]  channel_count,
   input  logic [srb_pkg::CEIL_W-1:0]  latency_ceiling,
   input  srb_pkg::cmd_type            cmd,
   output srb_pkg::status_type         status,
   output logic                        rsp_valid,
   output srb_pkg::rsp_type            rsp_data,
   input  logic                        rsp_stall
);

   localparam int PW    = $clog2(RING_DEPTH);
   localparam int LW    = $clog2(RING_DEPTH + 1);
   localparam int CW    = $clog2(MAX_POP + 1);
   localparam int KW    = srb_pkg::CEIL_W - 1;
   localparam int CMPW  = (LW > srb_pkg::CEIL_W) ? LW : srb_pkg::CEIL_W;
   localparam int AW    = ((PW > KW) ? PW : KW) + 1;
   localparam int NW    = (LW > srb_pkg::POP_MAX_W) ? LW : srb_pkg::POP_MAX_W;
   localparam int LVW   = srb_pkg::LEVEL_W;
   localparam int SW    = srb_pkg::SAMPLE_W;
   localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
   localparam logic [LW-1:0] DEPTH_L  = LW'(RING_DEPTH);
   localparam logic [AW-1:0] DEPTH_A  = AW'(RING_DEPTH);
   localparam logic [srb_pkg::POP_MAX_W-1:0] POP_CAP = srb_pkg::POP_MAX_W'(MAX_POP);

   logic [2*SW-1:0] frame_store_ff [RING_DEPTH];
   logic [2*SW-1:0] rd_data_ff;

   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   srb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic            full;
   logic [LW-1:0]   fill_push;
   logic [KW-1:0]   keep;
   logic            trim;
   logic [PW-1:0]   wp_next;
   logic [PW-1:0]   rp_next;
   logic [AW-1:0]   wn_a;
   logic [AW-1:0]   keep_a;
   logic [AW-1:0]   rp_trim_a;
   logic [srb_pkg::POP_MAX_W-1:0] req_cap;
   logic [NW-1:0]   fill_n;
   logic [NW-1:0]   req_n;
   logic [NW-1:0]   pop_n;
   logic [SW-1:0]   right_sample;
   logic            out_free;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PTR_LAST) ? '0 : PW'(p + 1'b1);
   endfunction

   assign full      = (fill_ff == DEPTH_L);
   assign fill_push = full ? fill_ff : LW'(fill_ff + 1'b1);
   assign keep      = latency_ceiling[srb_pkg::CEIL_W-1:1];
   assign trim      = req_data.end_of_packet &&
                      (CMPW'(fill_push) > CMPW'(latency_ceiling));
   assign wp_next   = ring_next(wp_ff);
   assign rp_next   = ring_next(rp_ff);
   assign wn_a      = AW'(wp_next);
   assign keep_a    = AW'(keep);
   assign rp_trim_a = (wn_a >= keep_a) ? AW'(wn_a - keep_a) : AW'(wn_a + DEPTH_A - keep_a);

   assign req_cap = (req_data.pop_max > POP_CAP) ? POP_CAP : req_data.pop_max;
   assign fill_n  = NW'(fill_ff);
   assign req_n   = NW'(req_cap);
   assign pop_n   = (fill_n < req_n) ? fill_n : req_n;

   assign right_sample = (channel_count > srb_pkg::CHAN_W'(1)) ?
                         req_data.sample_ch1 : req_data.sample_ch0;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.pop_none   = (pop_n == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = out_free;

   always_comb begin
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.push) begin
         wp_in = wp_next;
         if (trim) begin
            rp_in   = rp_trim_a[PW-1:0];
            fill_in = LW'(keep);
         end else begin
            fill_in = fill_push;
            if (full) begin
               rp_in = rp_next;
            end
         end
      end
      if (cmd.flush) begin
         fill_in = '0;
         wp_in   = rp_ff;
      end
      if (cmd.pop_start) begin
         count_in = CW'(pop_n);
      end
      if (cmd.read) begin
         rp_in    = rp_next;
         fill_in  = LW'(fill_ff - 1'b1);
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load_frame) begin
         rsp_data_in.left        = rd_data_ff[2*SW-1:SW];
         rsp_data_in.right       = rd_data_ff[SW-1:0];
         rsp_data_in.frame_valid = 1'b1;
         rsp_data_in.last        = (count_ff == '0);
         rsp_data_in.level       = LVW'(fill_ff);
      end else if (cmd.load_empty) begin
         rsp_data_in.left        = '0;
         rsp_data_in.right       = '0;
         rsp_data_in.frame_valid = 1'b0;
         rsp_data_in.last        = 1'b1;
         rsp_data_in.level       = LVW'(fill_ff);
      end
      if (cmd.load_frame || cmd.load_empty) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         frame_store_ff[wp_ff] <= {req_data.sample_ch0, right_sample};
      end
      if (cmd.read) begin
         rd_data_ff <= frame_store_ff[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/stereo_ring_buffer_latency_trim.sv */
// Push, flush and unknown beats yield no result.
// A pop beat of N frames reads each frame from the ring memory and then loads it into the
// output register, waiting while the output is stalled; an empty pop loads one empty result.
// The first result of a pop passes the READ and LOAD states; an empty pop only the EMPTY state.
// Synchronous active-high reset empties the ring and restores the registers
// (two channels, ceiling 2880); ring memory contents are not cleared.
module stereo_ring_buffer_latency_trim #(
   parameter int RING_DEPTH = srb_pkg::RING_DEPTH_DEFAULT,
   parameter int MAX_POP    = srb_pkg::MAX_POP_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  srb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output srb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [srb_pkg::CHAN_W-1:0] channel_count;
   logic [srb_pkg::CEIL_W-1:0] latency_ceiling;
   srb_pkg::cmd_type           cmd;
   srb_pkg::status_type        status;

   srb_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .channel_count   (channel_count),
      .latency_ceiling (latency_ceiling)
   );

   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srb_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_POP    (MAX_POP)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data        (req_data),
      .channel_count   (channel_count),
      .latency_ceiling (latency_ceiling),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .rsp_stall       (rsp_stall)
   );

   // The controller issues at most one command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.flush, cmd.pop_start, cmd.read,
                cmd.load_frame, cmd.load_empty}))
      else $error("more than one datapath command in a cycle");

   // Whenever the block is ready for a new beat, no frames of a pop are outstanding.
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> status.count_zero)
      else $error("frame counter not drained while idle");

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_frame || cmd.load_empty) |-> status.out_free)
      else $error("result loaded over a waiting beat");

   // A memory read is always followed by the load state, never directly by another read.
   assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> (req_stall && !cmd.read))
      else $error("read not followed by a load cycle");

endmodule
